>>> hw/rtl/nsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsb_pkg: shared types and constants of the n-th set bit select unit
// Widths of the stream fields, the queue entry layout and small popcounts.
// ----------------------------------------------------------------------------
package nsb_pkg;

	// field widths
	localparam int WORD_W  = 64;
	localparam int RANK_W  = 17;
	localparam int POS_W   = 17;
	localparam int CHUNK_W = 16;
	localparam int NCHUNK  = WORD_W / CHUNK_W;
	localparam int CC_W    = $clog2(CHUNK_W + 1);
	localparam int PC_W    = $clog2(WORD_W + 1);
	localparam int OFF_W   = $clog2(CHUNK_W);
	localparam int CIDX_W  = $clog2(NCHUNK);

	// stream packing
	localparam int IN_DATA_W  = ((WORD_W + RANK_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((POS_W + 1 + 7) / 8) * 8;

	// query limit and word counter
	localparam int MAX_WORDS = 1024;
	localparam int WC_W      = $clog2(MAX_WORDS + 1);

	// decoupling queue
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// one classified word between front and back
	typedef struct packed {
		logic [WORD_W-1:0]            word;
		logic [RANK_W-1:0]            rank;
		logic                         first;
		logic                         last;
		logic [NCHUNK-1:0][CC_W-1:0]  cc;
		logic [PC_W-1:0]              pc;
	} qent_t;

	// popcount of one 16-bit chunk
	function automatic logic [CC_W-1:0] popcnt16(input logic [CHUNK_W-1:0] v);
		logic [CC_W-1:0] c;
		c = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			c = c + CC_W'(v[i]);
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/nsb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsb_front: input side of the n-th set bit select unit
// Takes stream words, splits the fields and counts set bits per chunk.
// ----------------------------------------------------------------------------
module nsb_front (
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [nsb_pkg::IN_DATA_W-1:0] s_axis_tdata,  // word, rank, zero pad
	input  logic                          s_axis_tuser,  // first
	input  logic                          s_axis_tlast,
	output logic                          push,
	output nsb_pkg::qent_t                push_ent,
	input  logic                          q_full
);
	import nsb_pkg::*;

	logic [NCHUNK-1:0][CC_W-1:0] cc;
	logic [PC_W-1:0]             pc_sum;

	// chunk popcounts and word total
	always_comb begin
		pc_sum = '0;
		for (int c = 0; c < NCHUNK; c++) begin
			cc[c]  = popcnt16(s_axis_tdata[c*CHUNK_W +: CHUNK_W]);
			pc_sum = pc_sum + PC_W'(cc[c]);
		end
	end

	// queue write
	assign s_axis_tready  = !q_full;
	assign push           = s_axis_tvalid && !q_full;
	assign push_ent.word  = s_axis_tdata[WORD_W-1:0];
	assign push_ent.rank  = s_axis_tdata[WORD_W +: RANK_W];
	assign push_ent.first = s_axis_tuser;
	assign push_ent.last  = s_axis_tlast;
	assign push_ent.cc    = cc;
	assign push_ent.pc    = pc_sum;

endmodule

>>> hw/rtl/nsb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsb_fifo: short queue between front and back
// Register based, one write and one read per cycle.
// ----------------------------------------------------------------------------
module nsb_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nsb_pkg::qent_t push_ent,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output nsb_pkg::qent_t head_ent
);
	import nsb_pkg::*;

	qent_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_ent   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(do_pop);
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("empty queue with unequal pointers");

endmodule

>>> hw/rtl/nsb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsb_back: rank tracking and in-word select
// Stage 1 walks the rank across words, stage 2 picks the chunk,
// stage 3 finds the bit inside the chunk and holds the result.
// ----------------------------------------------------------------------------
module nsb_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           head_valid,
	input  nsb_pkg::qent_t                 head_ent,
	output logic                           pop,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [nsb_pkg::OUT_DATA_W-1:0] m_axis_tdata   // position, found, zero pad
);
	import nsb_pkg::*;

	// query state
	logic [RANK_W-1:0] rr_q;
	logic [WC_W-1:0]   wc_q;
	logic              done_q;

	// stage registers
	logic                        v_s1, hit_s1;
	logic [WORD_W-1:0]           word_s1;
	logic [PC_W-1:0]             r_s1;
	logic [NCHUNK-1:0][CC_W-1:0] cc_s1;
	logic [WC_W-1:0]             wc_s1;

	logic                        v_s2, hit_s2;
	logic [CHUNK_W-1:0]          chunk_s2;
	logic [CC_W-1:0]             r_s2;
	logic [CIDX_W-1:0]           cidx_s2;
	logic [WC_W-1:0]             wc_s2;

	logic                        v_s3, hit_s3;
	logic [POS_W-1:0]            pos_s3;

	logic adv;

	// stall the whole back end while the result waits
	assign adv = !v_s3 || m_axis_tready;
	assign pop = adv && head_valid;

	// stage 1: rank recurrence
	logic [RANK_W-1:0] rr_base, rr_nxt;
	logic [WC_W-1:0]   wc_base, wc_inc, wc_nxt;
	logic              done_nxt, emit, hit, reach;

	always_comb begin
		rr_base  = head_ent.first ? head_ent.rank : rr_q;
		wc_base  = head_ent.first ? '0 : wc_q;
		wc_inc   = wc_base + WC_W'(1);
		reach    = (rr_base <= RANK_W'(head_ent.pc));
		rr_nxt   = rr_base;
		wc_nxt   = wc_base;
		done_nxt = done_q;
		emit     = 1'b0;
		hit      = 1'b0;
		if (head_ent.first && head_ent.rank == '0) begin
			// rank zero ends at once
			done_nxt = 1'b1;
			emit     = 1'b1;
		end else if (head_ent.first || !done_q) begin
			done_nxt = 1'b0;
			if (reach) begin
				done_nxt = 1'b1;
				emit     = 1'b1;
				hit      = 1'b1;
			end else begin
				rr_nxt = rr_base - RANK_W'(head_ent.pc);
				wc_nxt = wc_inc;
				if (head_ent.last || wc_inc >= WC_W'(MAX_WORDS)) begin
					done_nxt = 1'b1;
					emit     = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q   <= '0;
			wc_q   <= '0;
			done_q <= 1'b1;
		end else if (pop) begin
			rr_q   <= rr_nxt;
			wc_q   <= wc_nxt;
			done_q <= done_nxt;
		end
	end

	// stage 2: chunk select from prefix counts
	logic [PC_W-1:0]   p1, p2, p3, rsub;
	logic [CIDX_W-1:0] cidx;

	always_comb begin
		p1 = PC_W'(cc_s1[0]);
		p2 = p1 + PC_W'(cc_s1[1]);
		p3 = p2 + PC_W'(cc_s1[2]);
		if (r_s1 <= p1) begin
			cidx = CIDX_W'(0);
			rsub = r_s1;
		end else if (r_s1 <= p2) begin
			cidx = CIDX_W'(1);
			rsub = r_s1 - p1;
		end else if (r_s1 <= p3) begin
			cidx = CIDX_W'(2);
			rsub = r_s1 - p2;
		end else begin
			cidx = CIDX_W'(3);
			rsub = r_s1 - p3;
		end
	end

	// stage 3: bit select inside the chunk
	logic [CHUNK_W-1:0] bit_hit;
	logic [OFF_W-1:0]   off;
	logic [WC_W+CIDX_W+OFF_W-1:0] pos_full;

	always_comb begin
		off = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			bit_hit[i] = chunk_s2[i] &&
				(popcnt16(chunk_s2 & CHUNK_W'((2 ** (i + 1)) - 1)) == r_s2);
			if (bit_hit[i]) begin
				off = off | OFF_W'(i);
			end
		end
		pos_full = {wc_s2, cidx_s2, off};
	end

	// control bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop && emit;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// payload of the stages
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s1   <= hit;
			word_s1  <= head_ent.word;
			r_s1     <= rr_base[PC_W-1:0];
			cc_s1    <= head_ent.cc;
			wc_s1    <= wc_base;
			hit_s2   <= hit_s1;
			chunk_s2 <= word_s1[cidx*CHUNK_W +: CHUNK_W];
			r_s2     <= rsub[CC_W-1:0];
			cidx_s2  <= cidx;
			wc_s2    <= wc_s1;
			hit_s3   <= hit_s2;
			pos_s3   <= hit_s2 ? POS_W'(pos_full) : '1;
		end
	end

	// result transfer
	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = OUT_DATA_W'({hit_s3, pos_s3});

	// checks
	a_notfound_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !hit_s3 |-> pos_s3 == '1)
		else $error("not-found result with a position");
	a_rank_in_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && hit_s2 |-> r_s2 != '0 && r_s2 <= CC_W'(CHUNK_W))
		else $error("chunk rank out of range");

endmodule

>>> hw/rtl/nth_set_bit_select_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nth_set_bit_select_unit: n-th set bit search over a streamed bitmap
// Front counts set bits, a four-entry queue decouples it from the back,
// which tracks the rank per word and selects the bit in three stages.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                               tuser   tlast
//  s_axis    in   word[63:0] rank[80:64] pad to 88    first   last
//  m_axis    out  position[16:0] found[17] pad to 24  -       -
//
//  One word per cycle unless the output or a full queue stalls; the rank
//  recurrence (popcount compare and subtract) closes in one back-end stage.
//  A result is registered through the queue and the three back-end stages.
//  Reset leaves the block idle until a word marked first.
//  Output stall holds the back end; the queue keeps taking words until full.
// ----------------------------------------------------------------------------
module nth_set_bit_select_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [nsb_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // word, rank, zero pad
	input  logic                           s_axis_tuser,   // first
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [nsb_pkg::OUT_DATA_W-1:0] m_axis_tdata    // position, found, zero pad
);
	import nsb_pkg::*;

	logic  push, q_full, pop, head_valid;
	qent_t push_ent, head_ent;

	// classify and count
	nsb_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.push          (push),
		.push_ent      (push_ent),
		.q_full        (q_full)
	);

	// decoupling queue
	nsb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ent   (push_ent),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_ent   (head_ent)
	);

	// rank walk and select
	nsb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_ent      (head_ent),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the n-th set bit select unit
// Streams bitmap queries into the block and checks each reported position
// against a rank-tracking predictor kept in the bench. Covers rank zero,
// restarts, ignored words, end of bitmap, the word limit and output stalls,
// followed by random queries of mixed bit density with and without idling.
// ----------------------------------------------------------------------------
module tb_top;
	import nsb_pkg::*;

	// one expected search result
	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             found;
	} bit_hit_t;

	localparam int DRAIN_CYCLES = 12;
	localparam logic [POS_W-1:0] NOT_FOUND = '1;
	localparam logic [RANK_W-1:0] RANK_MAX = '1;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;    // word, rank, zero pad
	logic                   s_axis_tuser = 1'b0;  // first
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;         // position, found, zero pad

	// predictor state
	logic [RANK_W-1:0] rank_left = '0;
	int unsigned       word_index = 0;
	bit                search_idle = 1'b1;
	bit_hit_t          pending_hits[$];

	// traffic control
	bit tx_gaps_en = 1'b0;
	bit rx_stall_en = 1'b0;
	int burst_left = 0;
	int rx_hold_req = 0;
	int rx_hold_left = 0;
	logic [15:0] rx_pattern = '1;
	int rx_phase = 0;

	// bookkeeping
	int mismatch_count = 0;
	int words_sent = 0;
	int query_words = 0;
	int hits_seen = 0;
	int misses_seen = 0;
	bit_hit_t got_hit;
	bit_hit_t want_hit;

	nth_set_bit_select_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// rank tracking per accepted word; returns 1 when the word belongs to a query
	function automatic bit predict_word(input logic [WORD_W-1:0] w, input logic [RANK_W-1:0] r,
		input bit f, input bit l);
		int unsigned pc;
		int unsigned seen;
		int unsigned off;
		if (f) begin
			word_index = 0;
			rank_left = r;
			search_idle = 1'b0;
			if (r == '0) begin
				pending_hits.push_back('{position: NOT_FOUND, found: 1'b0});
				search_idle = 1'b1;
				return 1'b1;
			end
		end else if (search_idle) begin
			return 1'b0;
		end
		pc = $countones(w);
		if (rank_left <= pc) begin
			seen = 0;
			off = 0;
			for (int i = 0; i < WORD_W; i++) begin
				if (w[i] && seen < rank_left) begin
					seen++;
					if (seen == rank_left) off = i;
				end
			end
			pending_hits.push_back('{position: POS_W'(word_index * WORD_W + off), found: 1'b1});
			search_idle = 1'b1;
			return 1'b1;
		end
		rank_left = rank_left - RANK_W'(pc);
		word_index++;
		if (l || word_index >= MAX_WORDS) begin
			pending_hits.push_back('{position: NOT_FOUND, found: 1'b0});
			search_idle = 1'b1;
		end
		return 1'b1;
	endfunction

	// one word transfer, with bursty gaps when enabled
	task automatic send_word(input logic [WORD_W-1:0] w, input logic [RANK_W-1:0] r,
		input bit f, input bit l);
		int gap;
		if (tx_gaps_en) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 16);
			end
			burst_left--;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_DATA_W - WORD_W - RANK_W){1'b0}}, r, w};
		s_axis_tuser <= f;
		s_axis_tlast <= l;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (predict_word(w, r, f, l)) query_words++;
		words_sent++;
	endtask

	// sender pause until every result is back, then let the pipeline settle
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_hits.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 6))
			0: return a & b & {$urandom, $urandom};
			1: return a | b;
			2: return '1;
			3: return '0;
			4: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
			default: return a;
		endcase
	endfunction

	// one query: mostly well formed, some noise and abandoned queries
	task automatic run_random_query();
		logic [WORD_W-1:0] words[$];
		logic [RANK_W-1:0] r;
		int kind;
		int len;
		int total;
		bit l;
		kind = $urandom_range(0, 99);
		if (kind < 6) begin
			send_word(rand_word(), RANK_W'($urandom_range(0, RANK_MAX)), 1'b0, 1'($urandom));
			return;
		end
		if (kind < 12) begin
			send_word(rand_word(), '0, 1'b1, 1'($urandom));
			return;
		end
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
		total = 0;
		for (int i = 0; i < len; i++) begin
			words.push_back(rand_word());
			total += $countones(words[i]);
		end
		if (kind < 17)
			r = RANK_W'($urandom_range(0, RANK_MAX));
		else
			r = RANK_W'($urandom_range(1, total + total / 4 + 1));
		for (int i = 0; i < len; i++) begin
			// abandoned queries may end without a last mark
			l = (i == len - 1) && (kind >= 22 || 1'($urandom));
			send_word(words[i], (i == 0) ? r : RANK_W'($urandom_range(0, RANK_MAX)), i == 0, l);
		end
	endtask

	// receiver: long hold-off on request, else a rolling stall pattern
	always @(posedge clk) begin
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_phase == 0) rx_pattern = 16'($urandom) | 16'($urandom);
		rx_phase = (rx_phase + 1) % 16;
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_stall_en) begin
			m_axis_tready <= rx_pattern[rx_phase];
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_hit.position = m_axis_tdata[POS_W-1:0];
			got_hit.found = m_axis_tdata[POS_W];
			if (pending_hits.size() == 0) begin
				report_mismatch($sformatf("unexpected result position %0h found %0b",
					got_hit.position, got_hit.found));
			end else begin
				want_hit = pending_hits.pop_front();
				if (got_hit.position !== want_hit.position)
					report_mismatch($sformatf("position %0h, wanted %0h",
						got_hit.position, want_hit.position));
				if (got_hit.found !== want_hit.found)
					report_mismatch($sformatf("found %0b, wanted %0b",
						got_hit.found, want_hit.found));
				if (want_hit.found) hits_seen++;
				else misses_seen++;
			end
		end
	end

	// edge cases of rank, position and query framing
	task automatic test_directed();
		tx_gaps_en = 1'b0;
		rx_stall_en = 1'b0;
		// word while idle is dropped
		send_word('1, 17'd1, 1'b0, 1'b1);
		// rank zero reports at once
		send_word('1, '0, 1'b1, 1'b0);
		// lowest and highest offset in one word
		send_word(64'h1, 17'd1, 1'b1, 1'b1);
		send_word('1, 17'd64, 1'b1, 1'b1);
		send_word(64'h8000_0000_0000_0000, 17'd1, 1'b1, 1'b0);
		// found in second word
		send_word('0, 17'd1, 1'b1, 1'b0);
		send_word(64'h8000_0000_0000_0000, RANK_MAX, 1'b0, 1'b1);
		// end of bitmap short of the rank
		send_word(64'hF, 17'd5, 1'b1, 1'b1);
		send_word('0, 17'd1, 1'b1, 1'b1);
		// restart abandons an open query
		send_word('0, 17'd3, 1'b1, 1'b0);
		send_word(64'h2, 17'd1, 1'b1, 1'b1);
		// large ranks run out
		send_word('1, RANK_MAX, 1'b1, 1'b0);
		send_word('1, '0, 1'b0, 1'b1);
		send_word('1, 17'h10000, 1'b1, 1'b1);
		// words after a hit are dropped
		send_word(64'h3, 17'd2, 1'b1, 1'b0);
		send_word('1, 17'd1, 1'b0, 1'b0);
		send_word('1, 17'd1, 1'b0, 1'b1);
		// rank spread across words with alternating bits
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 17'h0AAAA, 1'b1, 1'b0);
		send_word(64'h5555_5555_5555_5555, 17'h15555, 1'b0, 1'b1);
		wait_drain();
	endtask

	// word limit: a miss at the limit, then later words are dropped
	task automatic test_word_limit();
		tx_gaps_en = 1'b1;
		rx_stall_en = 1'b1;
		for (int i = 0; i < MAX_WORDS; i++)
			send_word('0, 17'd1, i == 0, 1'b0);
		send_word('1, 17'd1, 1'b0, 1'b0);
		send_word('1, 17'd1, 1'b0, 1'b1);
		wait_drain();
	endtask

	// long output hold-off while single-word queries keep coming
	task automatic test_backpressure();
		tx_gaps_en = 1'b0;
		rx_stall_en = 1'b0;
		rx_hold_req = 80;
		for (int i = 0; i < 30; i++) begin
			if (i % 3 == 0)
				send_word(rand_word(), '0, 1'b1, 1'b1);
			else
				send_word('1, RANK_W'($urandom_range(1, 70)), 1'b1, 1'b1);
		end
		wait_drain();
	endtask

	task automatic test_random(input int n_words, input bit idling);
		int start;
		tx_gaps_en = idling;
		rx_stall_en = idling;
		start = query_words;
		while (query_words - start < n_words) run_random_query();
		wait_drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_word_limit();
		test_backpressure();
		test_random(300, 1'b1);
		test_random(100, 1'b0);
		if (pending_hits.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_hits.size()));
		$display("summary: %0d words sent, %0d inside queries, %0d hits, %0d misses",
			words_sent, query_words, hits_seen, misses_seen);
		$display("summary: rank zero, restarts, idle words, word limit, output hold-off");
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("watchdog expired with %0d results outstanding", pending_hits.size());
		$display("status: fail");
		$finish;
	end

endmodule
